@@ design/mrpt_pkg.sv @@
// mrpt_pkg: shared types and constants for the primality test unit.
// Used by mrpt_ctrl, mrpt_dp and miller_rabin_prime_test_unit.
`default_nettype none
package mrpt_pkg;
  localparam int unsigned NumBases = 7;
  localparam int unsigned BaseIdxW = 3;
  localparam int unsigned Width = 64;

  function automatic logic [31:0] base_value(input logic [BaseIdxW-1:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'd2;
      3'd1: v = 32'd325;
      3'd2: v = 32'd9375;
      3'd3: v = 32'd28178;
      3'd4: v = 32'd450775;
      3'd5: v = 32'd9780504;
      3'd6: v = 32'd1795265022;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  typedef enum logic [3:0] {
    DpNop   = 4'd0,
    DpLoad  = 4'd1,
    DpShift = 4'd2,
    DpBase  = 4'd3,
    DpMulAX = 4'd4,
    DpMulXX = 4'd5,
    DpMulAA = 4'd6,
    DpStep  = 4'd7
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic trivial;   // negative, <=1 or even
    logic is_two;
    logic d_odd;     // shift finished
    logic step_last; // last bit step of a product
    logic x_zero;    // base vanished mod n
    logic e_bit;     // current exponent lsb
    logic e_last;    // exponent becomes zero after this bit
    logic a_one;
    logic a_nm1;
    logic sq_left;   // further squarings remain
  } dp_stat_t;
endpackage
`default_nettype wire

@@ design/mrpt_dp.sv @@
// mrpt_dp: datapath with a bit-serial modular multiplier.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_dp #(
  parameter int unsigned W = mrpt_pkg::Width
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [W-1:0]      cand_i,
  input  wire logic [mrpt_pkg::BaseIdxW-1:0] base_idx_i,
  input  wire mrpt_pkg::dp_cmd_t cmd_i,
  output mrpt_pkg::dp_stat_t     stat_o
);
  import mrpt_pkg::*;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0] n_q, d_q, e_q, x_q, a_q, r_q, y_q, m_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] s_q;
  logic [CW-1:0] j_q;     // squarings left for the current base
  logic dst_a_q;          // product goes to a, else to x
  logic [W:0] sh, ad;
  logic [W-1:0] r1, r2;

  // one double-and-add step, multiplier bits taken msb first; m < n
  always_comb begin
    sh = {r_q, 1'b0};
    r1 = (sh >= {1'b0, n_q}) ? W'(sh - {1'b0, n_q}) : sh[W-1:0];
    ad = {1'b0, r1} + {1'b0, m_q};
    if (y_q[W-1]) begin
      r2 = (ad >= {1'b0, n_q}) ? W'(ad - {1'b0, n_q}) : ad[W-1:0];
    end else begin
      r2 = r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0; d_q <= '0; e_q <= '0; x_q <= '0; a_q <= '0;
      r_q <= '0; y_q <= '0; m_q <= '0;
      cnt_q <= '0; s_q <= '0; j_q <= '0;
      dst_a_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DpLoad: begin
          n_q <= cand_i;
          d_q <= cand_i - W'(1);
          s_q <= '0;
        end
        DpShift: begin
          d_q <= d_q >> 1;
          s_q <= s_q + CW'(1);
        end
        DpBase: begin
          // base mod n as 1 * base
          m_q <= W'(1);
          y_q <= W'(base_value(base_idx_i));
          r_q <= '0;
          cnt_q <= '0;
          dst_a_q <= 1'b0;
          e_q <= d_q;
          a_q <= W'(1);
          j_q <= s_q - CW'(1);
        end
        DpMulAX: begin
          m_q <= a_q; y_q <= x_q; r_q <= '0; cnt_q <= '0; dst_a_q <= 1'b1;
        end
        DpMulXX: begin
          m_q <= x_q; y_q <= x_q; r_q <= '0; cnt_q <= '0; dst_a_q <= 1'b0;
          e_q <= e_q >> 1;
        end
        DpMulAA: begin
          m_q <= a_q; y_q <= a_q; r_q <= '0; cnt_q <= '0; dst_a_q <= 1'b1;
          j_q <= j_q - CW'(1);
        end
        DpStep: begin
          r_q <= r2;
          y_q <= y_q << 1;
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(W-1)) begin
            if (dst_a_q) a_q <= r2;
            else x_q <= r2;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat_o.trivial   = n_q[W-1] | (n_q <= W'(1)) | ~n_q[0];
  assign stat_o.is_two    = (n_q == W'(2));
  assign stat_o.d_odd     = d_q[0];
  assign stat_o.step_last = (cnt_q == CW'(W-1));
  assign stat_o.x_zero    = (x_q == '0);
  assign stat_o.e_bit     = e_q[0];
  assign stat_o.e_last    = (e_q[W-1:1] == '0);
  assign stat_o.a_one     = (a_q == W'(1));
  assign stat_o.a_nm1     = (a_q == n_q - W'(1));
  assign stat_o.sq_left   = (j_q != '0);
endmodule
`default_nettype wire

@@ design/mrpt_ctrl.sv @@
// mrpt_ctrl: sequencer for the Miller-Rabin test.
// Depends on mrpt_pkg; drives mrpt_dp by command.
`default_nettype none
module mrpt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   is_prime_o,
  output logic [mrpt_pkg::BaseIdxW-1:0] base_idx_o,
  output mrpt_pkg::dp_cmd_t      cmd_o,
  input  wire mrpt_pkg::dp_stat_t stat_i
);
  import mrpt_pkg::*;

  typedef enum logic [14:0] {
    SIdle  = 15'b000000000000001,
    SCheck = 15'b000000000000010,
    SShift = 15'b000000000000100,
    SBase  = 15'b000000000001000,
    SRed   = 15'b000000000010000,
    SZero  = 15'b000000000100000,
    SExp   = 15'b000000001000000,
    SMulA  = 15'b000000010000000,
    SAdv   = 15'b000000100000000,
    SSqX   = 15'b000001000000000,
    STest  = 15'b000010000000000,
    SSqA   = 15'b000100000000000,
    SChkA  = 15'b001000000000000,
    SPass  = 15'b010000000000000,
    SDone  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic [BaseIdxW-1:0] k_q, k_d;
  logic res_q, res_d;       // working verdict
  logic prime_q, prime_d;   // output register, held while stalled
  logic ov_q, ov_d;

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = ov_q;
  assign is_prime_o  = prime_q;
  assign base_idx_o  = k_q;

  always_comb begin
    state_d = state_q; k_d = k_q; res_d = res_q; prime_d = prime_q; ov_d = ov_q;
    cmd_o.op = DpNop;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o.op = DpLoad;
        state_d = SCheck;
      end
      SCheck: begin
        if (stat_i.trivial) begin
          res_d = stat_i.is_two;
          state_d = SDone;
        end else begin
          state_d = SShift;
        end
        k_d = '0;
      end
      SShift: begin
        if (stat_i.d_odd) state_d = SBase;
        else cmd_o.op = DpShift;
      end
      SBase: begin
        cmd_o.op = DpBase;
        state_d = SRed;
      end
      SRed: begin
        cmd_o.op = DpStep;
        if (stat_i.step_last) state_d = SZero;
      end
      // base that vanishes mod n counts as passed
      SZero: state_d = stat_i.x_zero ? SPass : SExp;
      SExp: begin
        if (stat_i.e_bit) begin
          cmd_o.op = DpMulAX;
          state_d = SMulA;
        end else begin
          state_d = SAdv;
        end
      end
      SMulA: begin
        cmd_o.op = DpStep;
        if (stat_i.step_last) state_d = SAdv;
      end
      SAdv: begin
        if (stat_i.e_last) begin
          state_d = STest;
        end else begin
          cmd_o.op = DpMulXX;
          state_d = SSqX;
        end
      end
      SSqX: begin
        cmd_o.op = DpStep;
        if (stat_i.step_last) state_d = SExp;
      end
      STest: begin
        if (stat_i.a_one || stat_i.a_nm1) begin
          state_d = SPass;
        end else if (stat_i.sq_left) begin
          cmd_o.op = DpMulAA;
          state_d = SSqA;
        end else begin
          res_d = 1'b0;
          state_d = SDone;
        end
      end
      SSqA: begin
        cmd_o.op = DpStep;
        if (stat_i.step_last) state_d = SChkA;
      end
      SChkA: begin
        if (stat_i.a_nm1) begin
          state_d = SPass;
        end else if (stat_i.sq_left) begin
          cmd_o.op = DpMulAA;
          state_d = SSqA;
        end else begin
          res_d = 1'b0;
          state_d = SDone;
        end
      end
      SPass: begin
        if (k_q == BaseIdxW'(NumBases-1)) begin
          res_d = 1'b1;
          state_d = SDone;
        end else begin
          k_d = k_q + BaseIdxW'(1);
          state_d = SBase;
        end
      end
      SDone: if (!ov_q || !out_stall_i) begin
        ov_d = 1'b1;
        prime_d = res_q;
        state_d = SIdle;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; k_q <= '0; res_q <= 1'b0; prime_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; k_q <= k_d; res_q <= res_d; prime_q <= prime_d; ov_q <= ov_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_prime_o))
    else $error("result dropped while stalled");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> in_stall_o)
    else $error("input open while busy");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
endmodule
`default_nettype wire

@@ design/miller_rabin_prime_test_unit.sv @@
// miller_rabin_prime_test_unit: top level of the 64-bit primality tester.
// Depends on mrpt_pkg, mrpt_ctrl and mrpt_dp.
//
// One candidate at a time: an item is taken when in_valid_i is high and
// in_stall_o low, and one is_prime result follows; in_stall_o stays high
// until the block is back in idle. Each modular product runs on a
// bit-serial double-and-add multiplier: a setup command, then one step
// per multiplier bit. Per bit of the odd part d of n-1 there is a multiply
// for a set bit and a square before the next bit; each base is first
// reduced mod n by a product and may need extra squarings, and a prime
// runs through all seven bases. Negative, zero, one and even candidates
// are settled in the check state without running any base. The result is
// held in an output register until taken, so the next item may be
// accepted while a result is still waiting.
`default_nettype none
module miller_rabin_prime_test_unit #(
  parameter int unsigned W = mrpt_pkg::Width
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [W-1:0] candidate_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic              is_prime_o
);
  import mrpt_pkg::*;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [BaseIdxW-1:0] base_idx;

  mrpt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .is_prime_o, .base_idx_o(base_idx), .cmd_o(cmd), .stat_i(stat)
  );

  mrpt_dp #(.W(W)) u_dp (
    .clk_i, .rst_ni, .cand_i(candidate_i), .base_idx_i(base_idx),
    .cmd_i(cmd), .stat_o(stat)
  );
endmodule
`default_nettype wire

@@ sim/miller_rabin_prime_test_unit_test.sv @@
// miller_rabin_prime_test_unit_test: self-checking bench for the 64-bit primality tester.
// Depends on mrpt_pkg and miller_rabin_prime_test_unit, which brings in mrpt_ctrl and mrpt_dp.
// A directed table runs first, then random candidates; every result is checked in order.
`default_nettype none
module miller_rabin_prime_test_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = mrpt_pkg::Width;
  localparam int unsigned NumRandom = 600;
  localparam int unsigned NumLarge = 6;      // full-width odd candidates are slow
  localparam int unsigned IdleLimit = 200000; // cycles with no item accepted or delivered
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned LongHold = 400;

  typedef struct {
    logic [W-1:0] candidate;
    bit           known;   // result typed in below
    bit           result;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] candidate_i = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic         is_prime_o;

  bit prime_queue[$];  // expected is_prime per accepted candidate, oldest first
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;   // long receiver hold-off, counted by the receiver process
  int unsigned hold_left = 0;
  int unsigned large_left = NumLarge;

  miller_rabin_prime_test_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .is_prime_o (is_prime_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // (x * y) mod m on a full 128-bit product
  function automatic logic [W-1:0] mulmod(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] m);
    logic [2*W-1:0] p;
    p = {{W{1'b0}}, x} * {{W{1'b0}}, y};
    return W'(p % {{W{1'b0}}, m});
  endfunction

  function automatic logic [W-1:0] powmod(logic [W-1:0] x, logic [W-1:0] e, logic [W-1:0] m);
    logic [W-1:0] acc;
    acc = 1;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, x, m);
      e = e >> 1;
      x = mulmod(x, x, m);
    end
    return acc;
  endfunction

  // Expected is_prime for one candidate: trivial screen, then the seven fixed bases.
  function automatic bit prime_expected(logic [W-1:0] n);
    logic [W-1:0] d, nm1, a;
    int s;
    bit ok;
    logic [W-1:0] bases[7];
    bases = '{2, 325, 9375, 28178, 450775, 9780504, 1795265022};
    if (n[W-1] || n <= 1 || !n[0]) return n == 2;
    nm1 = n - 1;
    d = nm1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    foreach (bases[k]) begin
      a = bases[k] % n;
      if (a == 0) continue;   // base vanishes mod n: counts as passed
      a = powmod(a, d, n);
      if (a == 1 || a == nm1) continue;
      ok = 0;
      for (int i = 0; i < s - 1 && !ok; i++) begin
        a = mulmod(a, a, n);
        if (a == nm1) ok = 1;
      end
      if (!ok) return 0;
    end
    return 1;
  endfunction

  // Random candidate: many cheap (negative, even, tiny), many small odd ones,
  // and only a handful of full-width odd values since those are slow.
  function automatic logic [W-1:0] random_candidate();
    int unsigned r;
    logic [W-1:0] v;
    r = $urandom_range(99);
    v = {$urandom, $urandom};
    if (r < 20) return {1'b1, v[W-2:0]};
    if (r < 40) return {v[W-1:1], 1'b0};
    if (r < 45) return W'($urandom_range(3));
    if (r < 98 || large_left == 0) return W'({$urandom_range(127), 1'b1});
    large_left--;
    return {1'b0, v[W-2:1], 1'b1};
  endfunction

  // Offer one candidate and hold it until accepted; the expectation is queued then.
  task automatic send_candidate(logic [W-1:0] c);
    int unsigned gap;
    in_valid_i <= 1'b1;
    candidate_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    prime_queue.insert(prime_queue.size(), prime_expected(c));
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (prime_queue.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: in order, against the oldest expectation.
  always @(posedge clk_i) begin
    bit want;
    if (out_valid_o && !out_stall_i) begin
      if (prime_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result is_prime=%0b", is_prime_o);
      end else begin
        want = prime_queue.pop_front();
        if (is_prime_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("is_prime mismatch: expected %0b, got %0b", want, is_prime_o);
        end
      end
    end
  end

  // Watchdog: no item moved on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    dir_rows = '{
      '{64'd0, 1, 0},
      '{64'd1, 1, 0},
      '{64'd2, 1, 1},
      '{64'd4, 1, 0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1, 0},   // -1
      '{64'h8000_0000_0000_0000, 1, 0},   // most negative
      '{64'hFFFF_FFFF_FFFF_FFFE, 1, 0},   // -2
      '{64'hFFFF_FFFF_FFFF_FFC5, 1, 0},   // 2^64-59 seen as negative
      '{64'd3, 0, 0},                     // base 9375 vanishes
      '{64'd5, 0, 0},                     // base 325 vanishes
      '{64'd7, 0, 0},
      '{64'd9, 0, 0},
      '{64'd13, 0, 0},
      '{64'd25, 0, 0},
      '{64'd325, 0, 0},
      '{64'd2047, 0, 0},                  // strong pseudoprime to base 2
      '{64'd3215031751, 0, 0},
      '{64'd1795265023, 0, 0},
      '{64'h7FFF_FFFF_FFFF_FFFF, 0, 0},   // largest positive, composite
      '{64'h7FFF_FFFF_FFFF_FFE7, 0, 0},   // largest 63-bit prime
      '{64'h1FFF_FFFF_FFFF_FFFF, 0, 0}    // 2^61-1, prime
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known && prime_expected(dir_rows[i].candidate) != dir_rows[i].result) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
      end
      send_candidate(dir_rows[i].candidate);
    end

    // Sender pauses until every result is back.
    wait_drained();

    for (int i = 0; i < NumRandom; i++) begin
      case (i / 150)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      // Long receiver hold-off while the sender keeps offering, so input stalls.
      if (i == 200) hold_req = LongHold;
      if (i == 450) wait_drained();
      send_candidate(random_candidate());
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
design/mrpt_pkg.sv
design/mrpt_dp.sv
design/mrpt_ctrl.sv
design/miller_rabin_prime_test_unit.sv
sim/miller_rabin_prime_test_unit_test.sv
